// ----- sv/pgrd_pkg.sv -----
// Shared types, constants and helper functions of the PPTP GRE receive deframer.
// Depends on nothing; every other file of the block imports it.
`default_nettype none
package pgrd_pkg;

	// Width of the saturating per-packet byte counter.
	localparam int COUNT_WIDTH = 17;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
	// Width used when the payload length is compared with the header length word.
	localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

	// Header constants.
	localparam int unsigned HDR_BYTES = 8;
	localparam logic [15:0] FLAG_MASK = 16'hEF7F;
	localparam logic [15:0] FLAG_VALUE = 16'h2001;
	localparam logic [15:0] FLAG_SEQ = 16'h1000;
	localparam logic [15:0] FLAG_ACK = 16'h0080;
	localparam logic [15:0] TYPE_PPP = 16'h880B;
	localparam logic [7:0] LEAD_ADDR_BYTE = 8'hFF;
	localparam logic [7:0] LEAD_CTRL_BYTE = 8'h03;
	localparam logic [4:0] OPT_WORD_BYTES = 5'd4;

	// Configuration port.
	localparam int PADDR_W = 3;
	localparam logic [0:0] REG_LOCAL_CALL_ID = 1'b0;

	// Queue between front and back end.
	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);
	localparam int SLOTS = 4;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_SHORT = 2'd1,
		ST_HDR = 2'd2,
		ST_LEN = 2'd3
	} status_t;

	// Progress of the leading address/control test.
	typedef enum logic [1:0] {
		HELD_NONE = 2'd0,
		HELD_ONE = 2'd1,
		HELD_STRIP = 2'd2
	} held_t;

	typedef enum logic {
		KIND_DATA = 1'b0,
		KIND_STATUS = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic [7:0] value;
		status_t st;
	} item_t;

	// All results caused by one input byte.
	typedef struct packed {
		logic [1:0] last_slot;
		item_t [SLOTS-1:0] slot;
	} entry_t;

	typedef struct packed {
		logic full;
		logic nonempty;
	} q_stat_t;

	function automatic item_t mk_item(kind_t kind, logic [7:0] value, status_t st);
		item_t it;
		it.kind = kind;
		it.value = value;
		it.st = st;
		return it;
	endfunction

	function automatic logic hdr_ok(logic [15:0] flags, logic [15:0] typ,
			logic [15:0] call, logic [15:0] call_id);
		return ((flags & FLAG_MASK) == FLAG_VALUE) && (typ == TYPE_PPP) && (call == call_id);
	endfunction

	function automatic logic [4:0] hdr_len(logic [15:0] flags);
		logic [4:0] n;
		n = 5'(HDR_BYTES);
		if ((flags & FLAG_SEQ) != 16'h0000) n = n + OPT_WORD_BYTES;
		if ((flags & FLAG_ACK) != 16'h0000) n = n + OPT_WORD_BYTES;
		return n;
	endfunction

endpackage
`default_nettype wire

// ----- sv/pgrd_front.sv -----
// Front end: accepts packet bytes, tracks the header and the leading PPP bytes,
// and writes the results of each byte, if any, as one queue entry. Uses pgrd_pkg.
`default_nettype none
module pgrd_front (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic accept,
	input  wire logic [7:0] data_byte,
	input  wire logic last_byte,
	input  wire logic [15:0] call_id,
	output logic wr_en,
	output pgrd_pkg::entry_t wr_entry
);
	import pgrd_pkg::*;

	logic [COUNT_WIDTH-1:0] cnt_q, cnt_n;
	logic [15:0] flag_q, flag_n, type_q, type_n, len_q, len_n, call_q, call_n;
	logic [7:0] held_q, held_n;
	held_t hcnt_q, hcnt_n;
	logic started_q, started_n;

	logic [2:0] n;
	item_t [SLOTS-1:0] slots;
	logic hok;
	logic [4:0] hlen_n;
	status_t st_v;

	always_comb begin
		flag_n = flag_q;
		type_n = type_q;
		len_n = len_q;
		call_n = call_q;
		held_n = held_q;
		hcnt_n = hcnt_q;
		started_n = started_q;
		slots = '0;
		n = 3'd0;
		hok = 1'b0;
		st_v = ST_OK;

		if (cnt_q < COUNT_WIDTH'(HDR_BYTES)) begin
			unique case (cnt_q[2:1])
				2'd0: flag_n = cnt_q[0] ? {flag_q[15:8], data_byte} : {data_byte, flag_q[7:0]};
				2'd1: type_n = cnt_q[0] ? {type_q[15:8], data_byte} : {data_byte, type_q[7:0]};
				2'd2: len_n = cnt_q[0] ? {len_q[15:8], data_byte} : {data_byte, len_q[7:0]};
				default: call_n = cnt_q[0] ? {call_q[15:8], data_byte} : {data_byte, call_q[7:0]};
			endcase
		end else if (hdr_ok(flag_q, type_q, call_q, call_id) &&
				cnt_q >= COUNT_WIDTH'(hdr_len(flag_q))) begin
			if (started_q) begin
				slots[n[1:0]] = mk_item(KIND_DATA, data_byte, ST_OK);
				n = n + 3'd1;
			end else begin
				unique case (hcnt_q)
					HELD_NONE: begin
						held_n = data_byte;
						hcnt_n = HELD_ONE;
					end
					HELD_ONE: begin
						if (held_q == LEAD_ADDR_BYTE && data_byte == LEAD_CTRL_BYTE) begin
							hcnt_n = HELD_STRIP;
						end else begin
							// An odd protocol byte gets a zero byte in front.
							if (held_q[0]) begin
								slots[n[1:0]] = mk_item(KIND_DATA, 8'h00, ST_OK);
								n = n + 3'd1;
							end
							slots[n[1:0]] = mk_item(KIND_DATA, held_q, ST_OK);
							n = n + 3'd1;
							slots[n[1:0]] = mk_item(KIND_DATA, data_byte, ST_OK);
							n = n + 3'd1;
							started_n = 1'b1;
							hcnt_n = HELD_NONE;
						end
					end
					default: begin
						if (data_byte[0]) begin
							slots[n[1:0]] = mk_item(KIND_DATA, 8'h00, ST_OK);
							n = n + 3'd1;
						end
						slots[n[1:0]] = mk_item(KIND_DATA, data_byte, ST_OK);
						n = n + 3'd1;
						started_n = 1'b1;
						hcnt_n = HELD_NONE;
					end
				endcase
			end
		end

		cnt_n = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + COUNT_WIDTH'(1);
		hlen_n = hdr_len(flag_n);

		if (last_byte) begin
			hok = (cnt_n >= COUNT_WIDTH'(HDR_BYTES)) && hdr_ok(flag_n, type_n, call_n, call_id);
			// A byte still held at the end is flushed before the status.
			if (hok && !started_n && hcnt_n == HELD_ONE) begin
				if (held_n[0]) begin
					slots[n[1:0]] = mk_item(KIND_DATA, 8'h00, ST_OK);
					n = n + 3'd1;
				end
				slots[n[1:0]] = mk_item(KIND_DATA, held_n, ST_OK);
				n = n + 3'd1;
			end
			priority if (cnt_n < COUNT_WIDTH'(HDR_BYTES)) st_v = ST_SHORT;
			else if (!hok) st_v = ST_HDR;
			else if (cnt_n < COUNT_WIDTH'(hlen_n)) st_v = ST_SHORT;
			else if (cnt_n == COUNT_MAX) st_v = ST_LEN;
			else if (CMP_W'(cnt_n - COUNT_WIDTH'(hlen_n)) != CMP_W'(len_n)) st_v = ST_LEN;
			else st_v = ST_OK;
			slots[n[1:0]] = mk_item(KIND_STATUS, 8'h00, st_v);
			n = n + 3'd1;
			cnt_n = '0;
			flag_n = '0;
			type_n = '0;
			len_n = '0;
			call_n = '0;
			held_n = '0;
			hcnt_n = HELD_NONE;
			started_n = 1'b0;
		end
	end

	assign wr_en = accept && (n != 3'd0);
	assign wr_entry.slot = slots;
	assign wr_entry.last_slot = 2'(n - 3'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			flag_q <= '0;
			type_q <= '0;
			len_q <= '0;
			call_q <= '0;
			held_q <= '0;
			hcnt_q <= HELD_NONE;
			started_q <= 1'b0;
		end else if (accept) begin
			cnt_q <= cnt_n;
			flag_q <= flag_n;
			type_q <= type_n;
			len_q <= len_n;
			call_q <= call_n;
			held_q <= held_n;
			hcnt_q <= hcnt_n;
			started_q <= started_n;
		end
	end

endmodule
`default_nettype wire

// ----- sv/pgrd_queue.sv -----
// Short register queue of result entries between front and back end.
// Uses pgrd_pkg.
`default_nettype none
module pgrd_queue (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  wire pgrd_pkg::entry_t wr_entry,
	input  wire logic rd_en,
	output pgrd_pkg::entry_t rd_entry,
	output pgrd_pkg::q_stat_t stat
);
	import pgrd_pkg::*;

	entry_t [QDEPTH-1:0] mem_q;
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QAW:0] cnt_q;
	logic do_wr, do_rd;

	assign stat.full = (cnt_q == (QAW+1)'(QDEPTH));
	assign stat.nonempty = (cnt_q != '0);
	assign do_wr = wr_en && !stat.full;
	assign do_rd = rd_en && stat.nonempty;
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QDEPTH-1)) ? '0 : wr_ptr_q + QAW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QDEPTH-1)) ? '0 : rd_ptr_q + QAW'(1);
			end
			unique case ({do_wr, do_rd})
				2'b10: cnt_q <= cnt_q + (QAW+1)'(1);
				2'b01: cnt_q <= cnt_q - (QAW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- sv/pgrd_back.sv -----
// Back end: walks the items of each queue entry into the result register,
// one result per cycle while pop is high or the register is empty. Uses pgrd_pkg.
`default_nettype none
module pgrd_back (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire pgrd_pkg::entry_t head,
	input  wire logic head_valid,
	output logic head_pop,
	input  wire logic pop,
	output logic empty,
	output pgrd_pkg::item_t out_item
);
	import pgrd_pkg::*;

	logic valid_q;
	logic [1:0] slot_q;
	item_t out_q;
	logic load;

	assign load = head_valid && (!valid_q || pop);
	assign head_pop = load && (slot_q == head.last_slot);
	assign empty = !valid_q;
	assign out_item = out_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= head.slot[slot_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			slot_q <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				slot_q <= (slot_q == head.last_slot) ? 2'd0 : slot_q + 2'd1;
			end else if (pop) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ----- sv/pptp_gre_receive_deframer.sv -----
// Top level of the PPTP enhanced GRE receive deframer: configuration register,
// front end, result queue and back end. Uses pgrd_pkg and the pgrd_* modules.
//
// Usage. The packet enters one byte per transaction on the input queue port
// (data_byte, last_byte; push while full is low), starting at the first byte of
// the GRE header, with last_byte high on its final byte. Results leave through
// the output queue port (item_kind, byte_value, status, is_last; taken with pop
// while empty is low): PPP payload bytes first, then one status transaction with
// is_last high. A status other than zero tells the consumer to drop the bytes it
// already received for that packet.
// The expected call id is written over the APB port at byte address 0 while the
// block is idle; it is compared with header bytes six and seven.
// Throughput: one input byte per cycle while full is low. Each byte is classified
// in the cycle it is accepted, and its results (zero to four), if any, are written
// as one entry into a four-entry queue; the back end drains one result per cycle
// from that queue while pop is high or the result register is empty.
// A byte's results pass through the queue and then the result register on their
// way to the result ports; the result register loads only while the output side is free.
// Stalls: while pop stays low the result register holds; the queue keeps
// absorbing bytes until it holds four entries, then full rises.
// Reset: arst_n clears all packet state, the queue and the call id register;
// the block accepts bytes as soon as reset is released.
`default_nettype none
module pptp_gre_receive_deframer (
	input  wire logic clk,
	input  wire logic arst_n,
	// Input queue side.
	input  wire logic push,
	output logic full,
	input  wire logic [7:0] data_byte,
	input  wire logic last_byte,
	// Result queue side.
	output logic empty,
	input  wire logic pop,
	output logic item_kind,
	output logic [7:0] byte_value,
	output logic [1:0] status,
	output logic is_last,
	// Configuration port.
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [pgrd_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import pgrd_pkg::*;

	logic [15:0] call_id_q;
	logic cfg_wr;
	logic in_acc;
	logic q_wr;
	entry_t q_wr_entry, q_head;
	q_stat_t q_stat;
	logic q_rd;
	item_t out_item;

	// The register index is taken from the word address; byte lanes are ignored.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready &&
		(paddr[PADDR_W-1:2] == REG_LOCAL_CALL_ID);

	always_comb begin
		if (paddr[PADDR_W-1:2] == REG_LOCAL_CALL_ID) begin
			prdata = {16'h0000, call_id_q};
		end else begin
			prdata = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			call_id_q <= '0;
		end else if (cfg_wr) begin
			call_id_q <= pwdata[15:0];
		end
	end

	// A byte is taken whenever the queue has room for its entry.
	assign full = q_stat.full;
	assign in_acc = push && !q_stat.full;

	pgrd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (in_acc),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.call_id   (call_id_q),
		.wr_en     (q_wr),
		.wr_entry  (q_wr_entry)
	);

	pgrd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (q_wr),
		.wr_entry (q_wr_entry),
		.rd_en    (q_rd),
		.rd_entry (q_head),
		.stat     (q_stat)
	);

	pgrd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_head),
		.head_valid (q_stat.nonempty),
		.head_pop   (q_rd),
		.pop        (pop),
		.empty      (empty),
		.out_item   (out_item)
	);

	assign item_kind = out_item.kind;
	assign byte_value = out_item.value;
	assign status = out_item.st;
	assign is_last = out_item.kind;

	// A full queue always has a head for the back end.
	a_full_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> q_stat.nonempty)
		else $error("queue reports full without a head entry");

	// The final byte of a packet always leaves an entry holding its status.
	a_last_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && last_byte) |=> q_stat.nonempty)
		else $error("final byte left no entry in the queue");

	// Payload transactions never carry a status code.
	a_data_status: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_item.kind == KIND_DATA) |-> (out_item.st == ST_OK))
		else $error("payload transaction carries a status code");

	// The back end never takes an entry from an empty queue.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_rd |-> q_stat.nonempty)
		else $error("entry taken from an empty queue");

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the PPTP enhanced GRE receive deframer.
// Depends on pgrd_pkg for the shared constants and enums and on pptp_gre_receive_deframer.
`timescale 1ns / 1ps
module tb;
	import pgrd_pkg::*;

	// Random bytes queued per random phase; with the directed packets the five
	// phases give roughly 330 in all.
	localparam int RAND_BYTES_PER_PHASE = 52;
	// The receiver holds off once, after this many bytes have gone in, for this many cycles.
	localparam int HOLD_AT = 60;
	localparam int HOLD_CYCLES = 60;
	// Cycles allowed after the last expected result before the block counts as idle.
	localparam int SETTLE_CYCLES = 8;
	// Cycles without any transaction on either side before the run is abandoned.
	localparam int QUIET_LIMIT = 4000;
	localparam logic [PADDR_W-1:0] CALL_ID_ADDR = PADDR_W'(4 * int'(REG_LOCAL_CALL_ID));

	typedef struct {
		logic [7:0] data;
		logic fin;
	} gre_byte_t;

	typedef struct {
		kind_t kind;
		logic [7:0] value;
		status_t st;
		logic fin;
	} deframed_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [7:0] data_byte = 8'h00;
	logic last_byte = 1'b0;
	logic empty;
	logic pop = 1'b0;
	logic item_kind;
	logic [7:0] byte_value;
	logic [1:0] status;
	logic is_last;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = 32'h0;
	logic [31:0] prdata;
	logic pready;

	pptp_gre_receive_deframer dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.empty(empty),
		.pop(pop),
		.item_kind(item_kind),
		.byte_value(byte_value),
		.status(status),
		.is_last(is_last),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Bytes waiting to be offered, the packet under construction, and the results
	// that the deframer is expected to produce, oldest first.
	gre_byte_t gre_bytes [$];
	logic [7:0] pkt [$];
	deframed_t deframed_q [$];

	// The testbench's own view of the deframer: the call id register and the
	// per-packet state.
	logic [15:0] call_id_reg = 16'h0000;
	logic [COUNT_WIDTH-1:0] rx_count = '0;
	logic [15:0] rx_flags = 16'h0;
	logic [15:0] rx_type = 16'h0;
	logic [15:0] rx_len = 16'h0;
	logic [15:0] rx_call = 16'h0;
	logic [7:0] rx_hold_byte = 8'h00;
	held_t rx_held = HELD_NONE;
	logic rx_started = 1'b0;

	bit idle_on = 1'b1;
	int errors = 0;
	int bytes_taken = 0;
	int results_seen = 0;
	int packets_queued = 0;
	int st_count [4] = '{0, 0, 0, 0};
	int send_gap = 0;
	int stall_left = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int quiet_cycles = 0;

	task automatic emit(input kind_t kind, input logic [7:0] value, input status_t st,
			input logic fin);
		deframed_t d;
		d.kind = kind;
		d.value = value;
		d.st = st;
		d.fin = fin;
		deframed_q.push_back(d);
	endtask

	// An odd first PPP byte is a compressed protocol field, so a zero byte goes
	// in front of it.
	task automatic emit_lead(input logic [7:0] b);
		if (b[0]) emit(KIND_DATA, 8'h00, ST_OK, 1'b0);
		emit(KIND_DATA, b, ST_OK, 1'b0);
	endtask

	// Works out the results of one accepted byte and advances the packet state.
	task automatic deframe_byte(input logic [7:0] b, input logic fin);
		logic [COUNT_WIDTH-1:0] idx;
		logic hdr_match;
		logic hok;
		int hlen;
		int total;
		status_t st;
		idx = rx_count;
		// The first eight bytes fill the four big-endian header words.
		if (idx < HDR_BYTES) begin
			if (idx[0]) begin
				case (idx[2:1])
					2'd0: rx_flags[7:0] = b;
					2'd1: rx_type[7:0] = b;
					2'd2: rx_len[7:0] = b;
					default: rx_call[7:0] = b;
				endcase
			end else begin
				case (idx[2:1])
					2'd0: rx_flags[15:8] = b;
					2'd1: rx_type[15:8] = b;
					2'd2: rx_len[15:8] = b;
					default: rx_call[15:8] = b;
				endcase
			end
		end
		hdr_match = ((rx_flags & FLAG_MASK) == FLAG_VALUE) && (rx_type == TYPE_PPP) &&
			(rx_call == call_id_reg);
		hlen = HDR_BYTES;
		if ((rx_flags & FLAG_SEQ) != 16'h0) hlen += int'(OPT_WORD_BYTES);
		if ((rx_flags & FLAG_ACK) != 16'h0) hlen += int'(OPT_WORD_BYTES);

		// Payload bytes pass only behind a matching header and its optional words.
		// The first byte is held until the address/control test can be decided.
		if (idx >= HDR_BYTES && hdr_match && int'(idx) >= hlen) begin
			if (rx_started) begin
				emit(KIND_DATA, b, ST_OK, 1'b0);
			end else if (rx_held == HELD_NONE) begin
				rx_hold_byte = b;
				rx_held = HELD_ONE;
			end else if (rx_held == HELD_ONE) begin
				if (rx_hold_byte == LEAD_ADDR_BYTE && b == LEAD_CTRL_BYTE) begin
					rx_held = HELD_STRIP;
				end else begin
					emit_lead(rx_hold_byte);
					emit(KIND_DATA, b, ST_OK, 1'b0);
					rx_started = 1'b1;
					rx_held = HELD_NONE;
				end
			end else begin
				emit_lead(b);
				rx_started = 1'b1;
				rx_held = HELD_NONE;
			end
		end
		if (rx_count != COUNT_MAX) rx_count++;

		if (fin) begin
			total = int'(rx_count);
			hok = (total >= HDR_BYTES) && hdr_match;
			// A single held byte is still flushed when the header matched, even if the length check rejects the packet.
			if (hok && !rx_started && rx_held == HELD_ONE) emit_lead(rx_hold_byte);
			if (total < HDR_BYTES) st = ST_SHORT;
			else if (!hok) st = ST_HDR;
			else if (total < hlen) st = ST_SHORT;
			else if (rx_count == COUNT_MAX) st = ST_LEN;
			else if (total - hlen != int'(rx_len)) st = ST_LEN;
			else st = ST_OK;
			emit(KIND_STATUS, 8'h00, st, 1'b1);
			st_count[st]++;
			rx_count = '0;
			rx_flags = 16'h0;
			rx_type = 16'h0;
			rx_len = 16'h0;
			rx_call = 16'h0;
			rx_hold_byte = 8'h00;
			rx_held = HELD_NONE;
			rx_started = 1'b0;
		end
	endtask

	// Sender: offers queued bytes one transaction at a time and feeds every
	// accepted byte to the prediction. After an accepted byte it sometimes pauses,
	// while idle_on is set, before it offers the next byte.
	always @(posedge clk) begin : driver
		gre_byte_t nxt;
		if (arst_n) begin
			if (push && !full) begin
				bytes_taken++;
				deframe_byte(data_byte, last_byte);
			end
			if (!push || !full) begin
				if (send_gap > 0) begin
					send_gap--;
					push <= 1'b0;
				end else if (push && idle_on && $urandom_range(0, 5) == 0) begin
					send_gap = $urandom_range(0, 7);
					push <= 1'b0;
				end else if (gre_bytes.size() != 0) begin
					nxt = gre_bytes.pop_front();
					push <= 1'b1;
					data_byte <= nxt.data;
					last_byte <= nxt.fin;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each result transaction against the oldest expectation and
	// decides pop for the next cycle. Once in the run it holds off for a long
	// stretch while the sender keeps going, so that the block fills and raises full.
	always @(posedge clk) begin : monitor
		deframed_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				results_seen++;
				if (deframed_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result: expected none, got %s",
						$time, $sformatf("kind %0d byte %02h status %0d last %0d",
						item_kind, byte_value, status, is_last));
				end else begin
					want = deframed_q.pop_front();
					if (item_kind !== want.kind || byte_value !== want.value ||
							status !== want.st || is_last !== want.fin) begin
						errors++;
						$display("%0t: result mismatch: expected %s, got %s", $time,
							$sformatf("kind %0d byte %02h status %0d last %0d",
							want.kind, want.value, want.st, want.fin),
							$sformatf("kind %0d byte %02h status %0d last %0d",
							item_kind, byte_value, status, is_last));
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (!hold_done && bytes_taken >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				pop <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 7);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Counts cycles in which no transaction happens on either side.
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) quiet_cycles = 0;
		else quiet_cycles++;
	end

	initial begin : watchdog
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("%0t: no transaction for %0d cycles, %0d results still expected",
			$time, QUIET_LIMIT, deframed_q.size());
		$display("end of test: mismatches");
		$finish;
	end

	task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] wdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Reads the call id register back and compares it with the expected value.
	task automatic check_call_id();
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= CALL_ID_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[15:0] !== call_id_reg) begin
			errors++;
			$display("%0t: call id readback mismatch: expected %04h, got %04h",
				$time, call_id_reg, prdata[15:0]);
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_call_id(input logic [15:0] id);
		apb_write(CALL_ID_ADDR, {16'h0000, id});
		call_id_reg = id;
		check_call_id();
	endtask

	// Waits until every queued byte has gone in and every expected result has
	// come out, then lets the pipeline settle before the register may change.
	task automatic wait_idle();
		do @(negedge clk); while (gre_bytes.size() != 0 || push || deframed_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic add_header(input logic [15:0] flags, input logic [15:0] typ,
			input logic [15:0] len, input logic [15:0] call);
		pkt.push_back(flags[15:8]);
		pkt.push_back(flags[7:0]);
		pkt.push_back(typ[15:8]);
		pkt.push_back(typ[7:0]);
		pkt.push_back(len[15:8]);
		pkt.push_back(len[7:0]);
		pkt.push_back(call[15:8]);
		pkt.push_back(call[7:0]);
	endtask

	// Moves the packet under construction to the sender, marking its final byte.
	task automatic commit_packet();
		gre_byte_t gb;
		foreach (pkt[i]) begin
			gb.data = pkt[i];
			gb.fin = (i == pkt.size() - 1);
			gre_bytes.push_back(gb);
		end
		pkt.delete();
		packets_queued++;
	endtask

	// Mostly well-formed packets with random options, payload and leading bytes;
	// the rest have a corrupted header word, a wrong length word, a cut-off tail,
	// or are plain random noise.
	task automatic add_random_packet();
		int sel;
		int plen;
		int lead;
		int k;
		int cut;
		logic [15:0] flags;
		logic [15:0] typ;
		logic [15:0] call;
		logic [15:0] len;
		sel = $urandom_range(0, 19);
		if (sel < 3) begin
			repeat ($urandom_range(1, 14)) pkt.push_back(8'($urandom));
		end else begin
			flags = FLAG_VALUE;
			if ($urandom_range(0, 1)) flags |= FLAG_SEQ;
			if ($urandom_range(0, 1)) flags |= FLAG_ACK;
			typ = TYPE_PPP;
			call = call_id_reg;
			if (sel < 6) begin
				case ($urandom_range(0, 2))
					0: begin
						do k = $urandom_range(0, 15); while (!FLAG_MASK[k]);
						flags ^= 16'(1) << k;
					end
					1: typ ^= 16'($urandom_range(1, 16'hFFFF));
					default: call ^= 16'($urandom_range(1, 16'hFFFF));
				endcase
			end
			plen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
			lead = $urandom_range(0, 3);
			len = 16'(plen);
			if ($urandom_range(0, 6) == 0) len = 16'($urandom);
			add_header(flags, typ, len, call);
			if ((flags & FLAG_SEQ) != 16'h0) repeat (4) pkt.push_back(8'($urandom));
			if ((flags & FLAG_ACK) != 16'h0) repeat (4) pkt.push_back(8'($urandom));
			for (k = 0; k < plen; k++) begin
				if (lead <= 1 && k == 0) pkt.push_back(LEAD_ADDR_BYTE);
				else if (lead == 0 && k == 1) pkt.push_back(LEAD_CTRL_BYTE);
				else pkt.push_back(8'($urandom));
			end
			if ($urandom_range(0, 9) == 0) begin
				cut = $urandom_range(1, pkt.size());
				while (pkt.size() > cut) void'(pkt.pop_back());
			end
		end
		commit_packet();
	endtask

	initial begin : stimulus
		logic [15:0] phase_id;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// The register must come out of reset as zero; the directed packets run
		// against that value.
		check_call_id();
		@(negedge clk);

		// A single byte is too short for any header.
		pkt.push_back(8'hFF);
		commit_packet();
		// Half a valid header is still too short.
		add_header(FLAG_VALUE, TYPE_PPP, 16'd0, call_id_reg);
		while (pkt.size() > 4) void'(pkt.pop_back());
		commit_packet();
		// A one-byte payload that is odd gets a zero byte in front of it.
		add_header(FLAG_VALUE, TYPE_PPP, 16'd1, call_id_reg);
		pkt.push_back(8'h81);
		commit_packet();
		// A payload of only the address/control pair produces no payload bytes.
		add_header(FLAG_VALUE, TYPE_PPP, 16'd2, call_id_reg);
		pkt.push_back(LEAD_ADDR_BYTE);
		pkt.push_back(LEAD_CTRL_BYTE);
		commit_packet();
		wait_idle();

		// Random phases over several call ids, the extremes among them; the last
		// ones run without idling on either side.
		for (int p = 0; p < 5; p++) begin
			case (p)
				0: phase_id = 16'hFFFF;
				2: phase_id = 16'h0000;
				default: phase_id = 16'($urandom);
			endcase
			set_call_id(phase_id);
			@(negedge clk);
			idle_on = (p < 3);
			while (gre_bytes.size() < RAND_BYTES_PER_PHASE) add_random_packet();
			wait_idle();
		end

		$display("Sent %0d packets (%0d bytes) and checked %0d results %s",
			packets_queued, bytes_taken, results_seen, "across six call id settings.");
		$display("Status totals: accepted %0d, too short %0d, %s %0d, %s %0d.",
			st_count[ST_OK], st_count[ST_SHORT], "header mismatch", st_count[ST_HDR],
			"length mismatch", st_count[ST_LEN]);
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
